[sv/mrm_pkg.sv]
// ============================================================================
// Modbus RTU master transaction package
// Shared types, constants and the CRC-16 byte update for the master block.
// ============================================================================
package mrm_pkg;

    // Reply buffer size and the widths that follow from it.
    localparam int BUF_BYTES = 256;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int FILL_W    = $clog2(BUF_BYTES + 1);
    localparam int RD_ADDR_W = 10;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [15:0] TIMEOUT_INIT = 16'd1000;
    localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;

    // Input item operation codes.
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_RX    = 3'd1;
    localparam logic [2:0] OP_FRAME = 3'd2;
    localparam logic [2:0] OP_TICK  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // Function codes that are decoded.
    localparam logic [7:0] FC_COILS    = 8'd1;
    localparam logic [7:0] FC_INPUTS   = 8'd2;
    localparam logic [7:0] FC_HOLDING  = 8'd3;
    localparam logic [7:0] FC_INPUTREG = 8'd4;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_PENDING = 2'd1,
        ST_DONE    = 2'd2,
        ST_ERROR   = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  slave_id;
        logic [7:0]  func_code;
        logic [15:0] start_address;
        logic [7:0]  quantity;
        logic [7:0]  rx_byte;
        logic [6:0]  read_index;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [1:0]  status;
        logic [15:0] read_value;
    } rsp_item_t;

    // Commands from the controller to the reply buffer.
    typedef struct packed {
        logic              clear;
        logic              wr_en;
        logic [7:0]        wr_byte;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
    } rx_cmd_t;

    // Receiver state reported back to the controller.
    typedef struct packed {
        logic [FILL_W-1:0] fill_count;
        logic              overflowed;
        logic [15:0]       crc;
        logic [7:0]        byte0;
        logic [7:0]        byte1;
        logic [7:0]        byte2;
    } rx_info_t;

    // Modbus CRC-16 (reflected) over one byte, one bit per step.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[sv/mrm_ram.sv]
// ============================================================================
// Generic RAM
// One write port and one read port with a registered read.
// ============================================================================
module mrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/mrm_rxbuf.sv]
// ============================================================================
// Reply receive buffer
// Stores reply bytes in two RAM copies, keeps the fill count, the overflow
// flag, the running CRC and copies of the first three bytes of the frame.
// ============================================================================
module mrm_rxbuf (
    input  logic             clk,
    input  logic             rst_n,
    input  mrm_pkg::rx_cmd_t cmd,
    output mrm_pkg::rx_info_t info,
    output logic [7:0]       rdata_a,
    output logic [7:0]       rdata_b
);
    import mrm_pkg::*;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        byte0_reg, byte0_next;
    logic [7:0]        byte1_reg, byte1_next;
    logic [7:0]        byte2_reg, byte2_next;
    logic              full;
    logic              do_write;

    assign full     = (fill_reg == FILL_W'(BUF_BYTES));
    assign do_write = cmd.wr_en && !full;

    always_comb
    begin
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        crc_next   = crc_reg;
        byte0_next = byte0_reg;
        byte1_next = byte1_reg;
        byte2_next = byte2_reg;
        if (cmd.clear)
        begin
            fill_next = '0;
            ovf_next  = 1'b0;
            crc_next  = CRC_INIT;
        end
        else if (cmd.wr_en)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
                crc_next  = crc_byte(crc_reg, cmd.wr_byte);
                // The header bytes are kept aside for the frame check.
                if (fill_reg == FILL_W'(0))
                begin
                    byte0_next = cmd.wr_byte;
                end
                if (fill_reg == FILL_W'(1))
                begin
                    byte1_next = cmd.wr_byte;
                end
                if (fill_reg == FILL_W'(2))
                begin
                    byte2_next = cmd.wr_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            crc_reg   <= CRC_INIT;
            byte0_reg <= '0;
            byte1_reg <= '0;
            byte2_reg <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            crc_reg   <= crc_next;
            byte0_reg <= byte0_next;
            byte1_reg <= byte1_next;
            byte2_reg <= byte2_next;
        end
    end

    // Two copies of the buffer so that a register word reads both bytes at once.
    mrm_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_ram_a (
        .clk   (clk),
        .we    (do_write),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (cmd.wr_byte),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr_a),
        .rdata (rdata_a)
    );

    mrm_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_ram_b (
        .clk   (clk),
        .we    (do_write),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (cmd.wr_byte),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr_b),
        .rdata (rdata_b)
    );

    assign info.fill_count = fill_reg;
    assign info.overflowed = ovf_reg;
    assign info.crc        = crc_reg;
    assign info.byte0      = byte0_reg;
    assign info.byte1      = byte1_reg;
    assign info.byte2      = byte2_reg;

endmodule

[sv/modbus_rtu_master_transaction.sv]
// ============================================================================
// Modbus RTU master transaction engine
// Builds read requests for functions 1 to 4, checks the reply and serves
// its data.
// ============================================================================
// Usage: items enter on the req channel and results leave on the rsp
// channel, both with valid and ready; the payloads are packed structs.
// A start item sends the eight request bytes as eight transmit results, one
// per cycle while the receiver takes them, and holds off further input until
// the last of them is taken. Every other item is taken at one per cycle while
// no result is held up. A received byte gives no result; frame end, tick and
// data read give one result each, which stands in the output register in the
// cycle after the item is accepted. A data read takes its bytes from the reply
// buffer RAM whose registered read port lines up with that output register.
// The request CRC is built one byte per cycle as the first six request bytes
// are taken. When the receiver stalls, the result holds and input is accepted
// again in the cycle in which the last result of the item is taken. Reset sets
// the timeout to 1000 ms and the status to idle; the reply buffer needs no
// clearing pass. The user must write the timeout through cfg_wr_en and
// cfg_wr_data only while the block is idle; the block does not enforce it.
// ============================================================================
module modbus_rtu_master_transaction (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               req_valid,
    output logic               req_ready,
    input  mrm_pkg::req_item_t req_data,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output mrm_pkg::rsp_item_t rsp_data
);
    import mrm_pkg::*;

    localparam logic [2:0] POS_ID      = 3'd0;
    localparam logic [2:0] POS_FUNC    = 3'd1;
    localparam logic [2:0] POS_ADDR_HI = 3'd2;
    localparam logic [2:0] POS_ADDR_LO = 3'd3;
    localparam logic [2:0] POS_QTY_HI  = 3'd4;
    localparam logic [2:0] POS_QTY_LO  = 3'd5;
    localparam logic [2:0] POS_CRC_LO  = 3'd6;
    localparam logic [2:0] POS_CRC_HI  = 3'd7;

    logic [15:0] timeout_reg, timeout_next;
    status_t     status_reg, status_next;
    logic [7:0]  exp_id_reg, exp_id_next;
    logic [7:0]  exp_func_reg, exp_func_next;
    logic [7:0]  req_count_reg, req_count_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] elapsed_reg, elapsed_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    status_t     out_status_reg, out_status_next;
    logic        out_rd_ok_reg, out_rd_ok_next;
    logic        out_rd_word_reg, out_rd_word_next;
    logic [2:0]  tx_cnt_reg, tx_cnt_next;
    logic [15:0] tx_crc_reg, tx_crc_next;

    rx_cmd_t     rx_cmd;
    rx_info_t    rx_info;
    logic [7:0]  rdata_a;
    logic [7:0]  rdata_b;

    logic        req_fire;
    logic        rsp_fire;
    logic        out_last;
    logic        has_result;
    logic [7:0]  tx_byte_cur;
    logic        fc_coil;
    logic        fc_reg;
    logic [8:0]  coil_cnt;
    logic [8:0]  sel_cnt;
    logic        frame_ok;
    logic [15:0] elapsed_inc;
    logic        rd_ok;
    logic [RD_ADDR_W-1:0] rd_addr_a_full;
    logic [RD_ADDR_W-1:0] rd_addr_b_full;

    assign fc_coil = (exp_func_reg == FC_COILS) || (exp_func_reg == FC_INPUTS);
    assign fc_reg  = (exp_func_reg == FC_HOLDING) || (exp_func_reg == FC_INPUTREG);

    // Output handshake: the item's last result frees the output register.
    assign out_last  = (out_kind_reg != KIND_TX) || (tx_cnt_reg == POS_CRC_HI);
    assign rsp_fire  = out_valid_reg && rsp_ready;
    assign req_ready = !out_valid_reg || (rsp_fire && out_last);
    assign req_fire  = req_valid && req_ready;
    assign has_result = (req_data.op == OP_START) || (req_data.op == OP_FRAME) ||
                        (req_data.op == OP_TICK) || (req_data.op == OP_READ);

    // Reply check at frame end.
    assign coil_cnt = ({1'b0, req_count_reg} + 9'd7) >> 3;
    assign sel_cnt  = fc_coil ? coil_cnt : {req_count_reg, 1'b0};
    assign frame_ok = (status_reg == ST_PENDING) && !rx_info.overflowed &&
                      (rx_info.fill_count > FILL_W'(5)) && (rx_info.crc == 16'h0000) &&
                      (rx_info.byte0 == exp_id_reg) && (rx_info.byte1 == exp_func_reg) &&
                      (fc_coil || fc_reg) && ({1'b0, rx_info.byte2} == sel_cnt) &&
                      (10'(rx_info.fill_count) == 10'd5 + {1'b0, sel_cnt});

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 16'd1;

    // Data read gating and buffer addresses.
    always_comb
    begin
        rd_ok = 1'b0;
        if (fc_coil)
        begin
            rd_addr_a_full = RD_ADDR_W'(3) + RD_ADDR_W'(req_data.read_index);
            rd_ok = ({1'b0, req_data.read_index} < rx_info.byte2);
        end
        else
        begin
            rd_addr_a_full = RD_ADDR_W'(3) + RD_ADDR_W'({req_data.read_index, 1'b0});
            rd_ok = fc_reg && ({1'b0, req_data.read_index} < req_count_reg) &&
                    ({req_data.read_index, 1'b1} < rx_info.byte2);
        end
        rd_addr_b_full = RD_ADDR_W'(4) + RD_ADDR_W'({req_data.read_index, 1'b0});
        if ((status_reg != ST_DONE) || (exp_id_reg == 8'h00))
        begin
            rd_ok = 1'b0;
        end
    end

    always_comb
    begin
        rx_cmd.clear     = req_fire && ((req_data.op == OP_START) ||
                                        (req_data.op == OP_FRAME));
        rx_cmd.wr_en     = req_fire && (req_data.op == OP_RX) && (status_reg == ST_PENDING);
        rx_cmd.wr_byte   = req_data.rx_byte;
        rx_cmd.rd_en     = req_fire && (req_data.op == OP_READ);
        rx_cmd.rd_addr_a = rd_addr_a_full[ADDR_W-1:0];
        rx_cmd.rd_addr_b = rd_addr_b_full[ADDR_W-1:0];
    end

    mrm_rxbuf u_rxbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (rx_cmd),
        .info    (rx_info),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        case (tx_cnt_reg)
            POS_ID:      tx_byte_cur = exp_id_reg;
            POS_FUNC:    tx_byte_cur = exp_func_reg;
            POS_ADDR_HI: tx_byte_cur = addr_reg[15:8];
            POS_ADDR_LO: tx_byte_cur = addr_reg[7:0];
            POS_QTY_HI:  tx_byte_cur = 8'h00;
            POS_QTY_LO:  tx_byte_cur = req_count_reg;
            POS_CRC_LO:  tx_byte_cur = tx_crc_reg[7:0];
            default:     tx_byte_cur = tx_crc_reg[15:8];
        endcase
    end

    // Transaction state and the output register.
    always_comb
    begin
        timeout_next   = cfg_wr_en ? cfg_wr_data : timeout_reg;
        status_next    = status_reg;
        exp_id_next    = exp_id_reg;
        exp_func_next  = exp_func_reg;
        req_count_next = req_count_reg;
        addr_next      = addr_reg;
        elapsed_next   = elapsed_reg;

        if (req_fire)
        begin
            case (req_data.op)
                OP_START:
                begin
                    exp_id_next    = req_data.slave_id;
                    exp_func_next  = req_data.func_code;
                    req_count_next = req_data.quantity;
                    addr_next      = req_data.start_address;
                    elapsed_next   = 16'd0;
                    status_next    = (req_data.slave_id != 8'h00) ? ST_PENDING : ST_DONE;
                end
                OP_FRAME:
                begin
                    if (frame_ok)
                    begin
                        status_next = ST_DONE;
                    end
                end
                OP_TICK:
                begin
                    if (status_reg == ST_PENDING)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc > timeout_reg)
                        begin
                            status_next = ST_ERROR;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        out_valid_next   = out_valid_reg;
        out_kind_next    = out_kind_reg;
        out_status_next  = out_status_reg;
        out_rd_ok_next   = out_rd_ok_reg;
        out_rd_word_next = out_rd_word_reg;
        tx_cnt_next      = tx_cnt_reg;
        tx_crc_next      = tx_crc_reg;

        if (rsp_fire)
        begin
            if (out_last)
            begin
                out_valid_next = 1'b0;
            end
            else
            begin
                tx_cnt_next = tx_cnt_reg + 3'd1;
                if (tx_cnt_reg < POS_CRC_LO)
                begin
                    tx_crc_next = crc_byte(tx_crc_reg, tx_byte_cur);
                end
            end
        end

        if (req_fire && has_result)
        begin
            out_valid_next   = 1'b1;
            out_status_next  = status_next;
            out_rd_ok_next   = rd_ok;
            out_rd_word_next = fc_reg;
            tx_cnt_next      = POS_ID;
            tx_crc_next      = CRC_INIT;
            case (req_data.op)
                OP_START: out_kind_next = KIND_TX;
                OP_READ:  out_kind_next = KIND_READ;
                default:  out_kind_next = KIND_STATUS;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_INIT;
            status_reg      <= ST_IDLE;
            exp_id_reg      <= '0;
            exp_func_reg    <= '0;
            req_count_reg   <= '0;
            addr_reg        <= '0;
            elapsed_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= KIND_STATUS;
            out_status_reg  <= ST_IDLE;
            out_rd_ok_reg   <= 1'b0;
            out_rd_word_reg <= 1'b0;
            tx_cnt_reg      <= POS_ID;
            tx_crc_reg      <= CRC_INIT;
        end
        else
        begin
            timeout_reg     <= timeout_next;
            status_reg      <= status_next;
            exp_id_reg      <= exp_id_next;
            exp_func_reg    <= exp_func_next;
            req_count_reg   <= req_count_next;
            addr_reg        <= addr_next;
            elapsed_reg     <= elapsed_next;
            out_valid_reg   <= out_valid_next;
            out_kind_reg    <= out_kind_next;
            out_status_reg  <= out_status_next;
            out_rd_ok_reg   <= out_rd_ok_next;
            out_rd_word_reg <= out_rd_word_next;
            tx_cnt_reg      <= tx_cnt_next;
            tx_crc_reg      <= tx_crc_next;
        end
    end

    // The RAM read data is stable while the read result waits in the output register.
    assign rsp_valid           = out_valid_reg;
    assign rsp_data.kind       = out_kind_reg;
    assign rsp_data.tx_byte    = (out_kind_reg == KIND_TX) ? tx_byte_cur : 8'h00;
    assign rsp_data.last       = out_last;
    assign rsp_data.status     = (out_kind_reg == KIND_TX) ? ST_IDLE : out_status_reg;
    assign rsp_data.read_value = ((out_kind_reg != KIND_READ) || !out_rd_ok_reg) ? 16'h0000 :
                                 out_rd_word_reg ? {rdata_a, rdata_b} : {8'h00, rdata_a};

    a_start_sends_tx: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (req_data.op == OP_START) |=>
            rsp_valid && (rsp_data.kind == KIND_TX) && (rsp_data.tx_byte == exp_id_reg))
        else $error("start did not present the station id as the first request byte");

    a_no_accept_mid_request: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.kind == KIND_TX) && !rsp_data.last |-> !req_ready)
        else $error("input accepted while request bytes were still being sent");

    a_read_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.kind == KIND_READ) && (rsp_data.read_value != 16'h0000) |->
            (status_reg == ST_DONE) && (exp_id_reg != 8'h00))
        else $error("reply data returned without a completed transaction");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rx_info.fill_count <= FILL_W'(BUF_BYTES))
        else $error("reply fill count beyond buffer size");

endmodule
